// File: hw/rtl/ftm_pkg.sv
package ftm_pkg;

  localparam int INTENSITY_BITS_DEF  = 16;
  localparam int MEMBERSHIP_BITS_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int CENTER_W    = 24;
  localparam int COEF_W      = 16;
  localparam int BIAS_W      = 16;

  localparam logic [CENTER_W-1:0] CENTER_RST = '0;
  localparam logic [COEF_W-1:0]   LAMBDA_RST = 16'd256;
  localparam logic [COEF_W-1:0]   WEIGHT_RST = 16'd4096;
  localparam logic [COEF_W-1:0]   FUZZ_RST   = 16'd8192;
  localparam logic [COEF_W-1:0]   FUZZ_ONE   = 16'd4096;

  // 1/(q-1) in Q.16; q - 1 down to 2^-12 gives at most 2^28
  localparam int                 RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] RECIP_RST = 29'd65536;

  localparam int LOG_FRAC_W = 16;
  localparam int EXP_W      = 31;
  localparam int ROM_W      = 30;
  localparam int TOT_W      = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_CSF = 3'd0,
    REG_CENTER_GM  = 3'd1,
    REG_CENTER_WM  = 3'd2,
    REG_LAMBDA     = 3'd3,
    REG_WEIGHT_CSF = 3'd4,
    REG_WEIGHT_GM  = 3'd5,
    REG_WEIGHT_WM  = 3'd6,
    REG_FUZZINESS  = 3'd7
  } ftm_reg_e;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // width of the weighted cost e = (d1^2 + (d2^2*lambda << 16)) * w + 1
  function automatic int cost_width(input int ib);
    int pw;
    int a1w;
    int a2w;
    int sw;
    pw  = CENTER_W + 1 + BIAS_W;
    a1w = max_int(ib + 21, pw);
    a2w = max_int(ib + 9, CENTER_W + 1);
    sw  = max_int(2 * a1w, 2 * a2w + 32) + 1;
    return sw + COEF_W;
  endfunction

  // c_0 = 2^29, c_i = floor(sqrt(c_(i-1) * 2^30)): c_i ~ 2^30 * 2^(-2^-i)
  function automatic logic [ROM_W-1:0] exp_rom(input int idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      if (i <= idx) begin
        v = c << 30;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
          if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
        c = r;
      end
    end
    return c[ROM_W-1:0];
  endfunction

endpackage

// File: hw/rtl/fuzzy_tissue_membership_update_core.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | intensity, bias, in_roi, old_*, end_of_volume
// out     | output    | out_valid_o/out_ready_i | new_*, last_voxel
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (register write)
//
// One voxel per cycle while no reciprocal runs and the skid slot is empty. A voxel
// crosses 48 + MEMBERSHIP_BITS registers (64 at default): 25 cost/log, 21 exponent,
// MEMBERSHIP_BITS+1 divider and the output register. A write to fuzziness starts a
// bit-serial reciprocal; in_ready_o and cfg_ready_o stay low while it runs. Reset
// restores register defaults at once. The pipeline advances whenever the output skid
// slot is empty; in_ready_o drops the cycle after a stalled result lands in the skid
// slot, with no loss or repeat.
module fuzzy_tissue_membership_update_core #(
  parameter int INTENSITY_BITS  = ftm_pkg::INTENSITY_BITS_DEF,
  parameter int MEMBERSHIP_BITS = ftm_pkg::MEMBERSHIP_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [INTENSITY_BITS-1:0]         intensity_i,
  input  logic signed [ftm_pkg::BIAS_W-1:0] bias_i,
  input  logic                              in_roi_i,
  input  logic [MEMBERSHIP_BITS-1:0]        old_csf_i,
  input  logic [MEMBERSHIP_BITS-1:0]        old_gm_i,
  input  logic [MEMBERSHIP_BITS-1:0]        old_wm_i,
  input  logic                              end_of_volume_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [MEMBERSHIP_BITS-1:0]        new_csf_o,
  output logic [MEMBERSHIP_BITS-1:0]        new_gm_o,
  output logic [MEMBERSHIP_BITS-1:0]        new_wm_o,
  output logic                              last_voxel_o,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ftm_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [ftm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int MB      = MEMBERSHIP_BITS;
  localparam int LOG_W   = $clog2(ftm_pkg::cost_width(INTENSITY_BITS)) + ftm_pkg::LOG_FRAC_W;
  localparam int PRW     = LOG_W + ftm_pkg::RECIP_W;
  localparam int S_W     = PRW - 16;
  localparam int M_W     = S_W - 16;
  localparam int EXP_W   = ftm_pkg::EXP_W;
  localparam int COST_LAT = 25;
  localparam int LAT     = COST_LAT + 3 + 16 + 2 + MB + 1;
  localparam int SIDE_W  = 3 * MB + 2;
  localparam int RES_W   = 3 * MB + 1;
  localparam int CNT_W   = $clog2(ftm_pkg::RECIP_W);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ftm_pkg::CENTER_W-1:0] center_q [3];
  logic [ftm_pkg::COEF_W-1:0]   weight_q [3];
  logic [ftm_pkg::COEF_W-1:0]   lambda_q;
  logic [ftm_pkg::COEF_W-1:0]   fuzz_q;
  logic                         cfg_wr;
  logic                         rcp_busy;

  assign cfg_ready_o = !rcp_busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        center_q[k] <= ftm_pkg::CENTER_RST;
        weight_q[k] <= ftm_pkg::WEIGHT_RST;
      end
      lambda_q <= ftm_pkg::LAMBDA_RST;
      fuzz_q   <= ftm_pkg::FUZZ_RST;
    end else if (cfg_wr) begin
      unique case (ftm_pkg::ftm_reg_e'(cfg_index_i))
        ftm_pkg::REG_CENTER_CSF: center_q[0] <= cfg_data_i;
        ftm_pkg::REG_CENTER_GM:  center_q[1] <= cfg_data_i;
        ftm_pkg::REG_CENTER_WM:  center_q[2] <= cfg_data_i;
        ftm_pkg::REG_LAMBDA:     lambda_q    <= cfg_data_i[ftm_pkg::COEF_W-1:0];
        ftm_pkg::REG_WEIGHT_CSF: weight_q[0] <= cfg_data_i[ftm_pkg::COEF_W-1:0];
        ftm_pkg::REG_WEIGHT_GM:  weight_q[1] <= cfg_data_i[ftm_pkg::COEF_W-1:0];
        ftm_pkg::REG_WEIGHT_WM:  weight_q[2] <= cfg_data_i[ftm_pkg::COEF_W-1:0];
        ftm_pkg::REG_FUZZINESS:  fuzz_q      <= cfg_data_i[ftm_pkg::COEF_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Reciprocal r = floor(2^28 / (q - 1)) in Q.16, restoring, one bit a cycle.
  // The numerator is a single one followed by zeros, shifted in MSB first.
  // ---------------------------------------------------------------------------
  typedef enum logic {R_IDLE, R_RUN} rcp_state_e;

  rcp_state_e                   rcp_state_q;
  logic [ftm_pkg::RECIP_W-1:0]  recip_q;
  logic [CNT_W-1:0]             rcp_cnt_q;
  logic [ftm_pkg::COEF_W-1:0]   rcp_rem_q, rcp_rem_d;
  logic [ftm_pkg::COEF_W-1:0]   rcp_den_q;
  logic [ftm_pkg::COEF_W:0]     rcp_trial;
  logic                         rcp_ge;

  assign rcp_busy  = (rcp_state_q == R_RUN);
  assign rcp_trial = {rcp_rem_q, (rcp_cnt_q == '0)};
  assign rcp_ge    = rcp_trial >= {1'b0, rcp_den_q};
  assign rcp_rem_d = rcp_ge ? ftm_pkg::COEF_W'(rcp_trial - {1'b0, rcp_den_q})
                            : rcp_trial[ftm_pkg::COEF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcp_state_q <= R_IDLE;
      recip_q     <= ftm_pkg::RECIP_RST;
      rcp_cnt_q   <= '0;
      rcp_rem_q   <= '0;
      rcp_den_q   <= '0;
    end else begin
      unique case (rcp_state_q)
        R_IDLE: begin
          if (cfg_wr && (cfg_index_i == ftm_pkg::REG_FUZZINESS)) begin
            rcp_den_q   <= cfg_data_i[ftm_pkg::COEF_W-1:0] - ftm_pkg::FUZZ_ONE;
            rcp_rem_q   <= '0;
            rcp_cnt_q   <= '0;
            rcp_state_q <= R_RUN;
          end
        end
        R_RUN: begin
          rcp_rem_q <= rcp_rem_d;
          recip_q   <= {recip_q[ftm_pkg::RECIP_W-2:0], rcp_ge};
          rcp_cnt_q <= rcp_cnt_q + CNT_W'(1);
          if (rcp_cnt_q == CNT_W'(ftm_pkg::RECIP_W - 1)) begin
            rcp_state_q <= R_IDLE;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together while the skid slot is free
  // ---------------------------------------------------------------------------
  logic             pipe_adv;
  logic             in_xfer;
  logic [LAT-1:0]   vld_q;
  logic [SIDE_W-1:0] side_q [LAT];
  logic             skid_valid_q;

  assign pipe_adv   = !skid_valid_q;
  assign in_ready_o = pipe_adv && !rcp_busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_adv) begin
      vld_q <= {vld_q[LAT-2:0], in_xfer};
    end
  end

  // carry the pass-through fields alongside the math
  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      side_q[0] <= {end_of_volume_i, in_roi_i, old_wm_i, old_gm_i, old_csf_i};
      for (int j = 1; j < LAT; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per class: cost and log2 (25 stages)
  // ---------------------------------------------------------------------------
  logic [LOG_W-1:0] log_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_cost
    ftm_cost_log #(
      .INTENSITY_BITS (INTENSITY_BITS)
    ) u_cost_log (
      .clk_i       (clk_i),
      .adv_i       (pipe_adv),
      .intensity_i (intensity_i),
      .bias_i      (bias_i),
      .center_i    (center_q[k]),
      .weight_i    (weight_q[k]),
      .lambda_i    (lambda_q),
      .log_o       (log_w[k])
    );
  end

  // minimum of the three logs
  logic [LOG_W-1:0] lmin_d, lmin_q;
  logic [LOG_W-1:0] lcp_q  [3];
  logic [LOG_W-1:0] diff_q [3];
  logic [PRW-1:0]   prod_q [3];

  always_comb begin
    lmin_d = log_w[0];
    if (log_w[1] < lmin_d) lmin_d = log_w[1];
    if (log_w[2] < lmin_d) lmin_d = log_w[2];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      lmin_q <= lmin_d;
      for (int k = 0; k < 3; k++) begin
        lcp_q[k]  <= log_w[k];
        diff_q[k] <= lcp_q[k] - lmin_q;
        prod_q[k] <= diff_q[k] * recip_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per class: 2^-s, one fraction bit per stage, then integer shift and sum
  // ---------------------------------------------------------------------------
  logic [EXP_W-1:0] u_q  [3];
  logic [EXP_W-1:0] u2_q [3];
  logic [ftm_pkg::TOT_W-1:0] tot_q;

  for (genvar k = 0; k < 3; k++) begin : g_exp
    logic [S_W-1:0]   s_q [16];
    logic [EXP_W-1:0] v_q [16];
    logic [M_W-1:0]   m;

    for (genvar i = 1; i <= 16; i++) begin : g_step
      localparam logic [ftm_pkg::ROM_W-1:0] ROM_C = ftm_pkg::exp_rom(i);
      logic [S_W-1:0]                  s_in;
      logic [EXP_W-1:0]                v_in;
      logic [EXP_W+ftm_pkg::ROM_W-1:0] vp;

      if (i == 1) begin : g_first
        assign s_in = prod_q[k][PRW-1:16];
        assign v_in = EXP_W'(1) << 30;
      end else begin : g_next
        assign s_in = s_q[i-2];
        assign v_in = v_q[i-2];
      end

      assign vp = v_in * ROM_C;

      always_ff @(posedge clk_i) begin
        if (pipe_adv) begin
          s_q[i-1] <= s_in;
          v_q[i-1] <= s_in[16-i] ? vp[EXP_W+29:30] : v_in;
        end
      end
    end

    assign m = s_q[15][S_W-1:16];

    always_ff @(posedge clk_i) begin
      if (pipe_adv) begin
        u_q[k]  <= (m >= M_W'(31)) ? '0 : (v_q[15] >> m[4:0]);
        u2_q[k] <= u_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      tot_q <= ftm_pkg::TOT_W'(u_q[0]) + ftm_pkg::TOT_W'(u_q[1])
             + ftm_pkg::TOT_W'(u_q[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // Per class: rounded u / S, MEMBERSHIP_BITS+1 stages
  // ---------------------------------------------------------------------------
  logic [MB:0]   quo_w [3];
  logic [MB-1:0] sat_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    ftm_norm_div #(
      .MEMBERSHIP_BITS (MB)
    ) u_norm_div (
      .clk_i (clk_i),
      .adv_i (pipe_adv),
      .u_i   (u2_q[k]),
      .tot_i (tot_q),
      .quo_o (quo_w[k])
    );

    // a membership of one saturates to the largest code
    assign sat_w[k] = quo_w[k][MB] ? '1 : quo_w[k][MB-1:0];
  end

  // ---------------------------------------------------------------------------
  // Result select: pass old memberships when q <= 1, zero outside the ROI
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] side_last;
  logic              pass_thru;
  logic [RES_W-1:0]  res;

  assign side_last = side_q[LAT-1];
  assign pass_thru = (fuzz_q <= ftm_pkg::FUZZ_ONE);

  always_comb begin
    if (pass_thru) begin
      res = {side_last[SIDE_W-1], side_last[3*MB-1:0]};
    end else if (!side_last[3*MB]) begin
      res = {side_last[SIDE_W-1], {(3*MB){1'b0}}};
    end else begin
      res = {side_last[SIDE_W-1], sat_w[2], sat_w[1], sat_w[0]};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid slot
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [RES_W-1:0] out_q;
  logic [RES_W-1:0] skid_q;
  logic             out_xfer;
  logic             new_res;

  assign out_xfer = out_valid_q && out_ready_i;
  assign new_res  = pipe_adv && vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain the skid slot first; the pipeline holds meanwhile
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_xfer) begin
      out_valid_q <= new_res;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) out_q <= skid_q;
    end else if (!out_valid_q || out_xfer) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_csf_o    = out_q[MB-1:0];
  assign new_gm_o     = out_q[2*MB-1:MB];
  assign new_wm_o     = out_q[3*MB-1:2*MB];
  assign last_voxel_o = out_q[RES_W-1];

endmodule

// File: hw/rtl/ftm_cost_log.sv
module ftm_cost_log #(
  parameter int INTENSITY_BITS = ftm_pkg::INTENSITY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic [INTENSITY_BITS-1:0]           intensity_i,
  input  logic signed [ftm_pkg::BIAS_W-1:0]   bias_i,
  input  logic [ftm_pkg::CENTER_W-1:0]        center_i,
  input  logic [ftm_pkg::COEF_W-1:0]          weight_i,
  input  logic [ftm_pkg::COEF_W-1:0]          lambda_i,
  output logic [$clog2(ftm_pkg::cost_width(INTENSITY_BITS))+ftm_pkg::LOG_FRAC_W-1:0] log_o
);

  localparam int PW  = ftm_pkg::CENTER_W + 1 + ftm_pkg::BIAS_W;
  localparam int A1W = ftm_pkg::max_int(INTENSITY_BITS + 21, PW);
  localparam int D1W = A1W + 1;
  localparam int A2W = ftm_pkg::max_int(INTENSITY_BITS + 9, ftm_pkg::CENTER_W + 1);
  localparam int D2W = A2W + 1;
  localparam int H   = (A1W + 1) / 2;
  localparam int HH  = A1W - H;
  localparam int T1W = 2 * A1W;
  localparam int T2W = 2 * A2W + ftm_pkg::COEF_W;
  localparam int SW  = ftm_pkg::max_int(T1W, T2W + 16) + 1;
  localparam int SH  = (SW + 1) / 2;
  localparam int EW  = ftm_pkg::cost_width(INTENSITY_BITS);
  localparam int NW  = $clog2(EW);
  localparam int FW  = ftm_pkg::LOG_FRAC_W;

  // stage 1: center * bias, bias-free distance
  logic signed [PW-1:0]      cb_d, cb_q;
  logic signed [D2W-1:0]     d2, d2_neg;
  logic [A2W-1:0]            a2_d, a2_q;
  logic [INTENSITY_BITS-1:0] i1_q;

  assign cb_d   = $signed({1'b0, center_i}) * bias_i;
  assign d2     = $signed({{(D2W-INTENSITY_BITS-8){1'b0}}, intensity_i, 8'b0})
                - $signed({{(D2W-ftm_pkg::CENTER_W){1'b0}}, center_i});
  assign d2_neg = -d2;
  assign a2_d   = d2[D2W-1] ? d2_neg[A2W-1:0] : d2[A2W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cb_q <= cb_d;
      a2_q <= a2_d;
      i1_q <= intensity_i;
    end
  end

  // stage 2: biased distance magnitude
  logic signed [D1W-1:0] d1, d1_neg;
  logic [A1W-1:0]        a1_d, a1_q;
  logic [A2W-1:0]        a2b_q;

  assign d1     = $signed({{(D1W-INTENSITY_BITS-20){1'b0}}, i1_q, 20'b0})
                - $signed({{(D1W-PW){cb_q[PW-1]}}, cb_q});
  assign d1_neg = -d1;
  assign a1_d   = d1[D1W-1] ? d1_neg[A1W-1:0] : d1[A1W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q  <= a1_d;
      a2b_q <= a2_q;
    end
  end

  // stage 3: partial products of the squares
  logic [2*HH-1:0]  hh_q;
  logic [HH+H-1:0]  hl_q;
  logic [2*H-1:0]   ll_q;
  logic [2*A2W-1:0] a2sq_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hh_q   <= a1_q[A1W-1:H] * a1_q[A1W-1:H];
      hl_q   <= a1_q[A1W-1:H] * a1_q[H-1:0];
      ll_q   <= a1_q[H-1:0] * a1_q[H-1:0];
      a2sq_q <= a2b_q * a2b_q;
    end
  end

  // stage 4: merge first square, scale second by lambda
  logic [T1W-1:0] t1_q;
  logic [T2W-1:0] t2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t1_q <= (T1W'(hh_q) << (2 * H)) + (T1W'(hl_q) << (H + 1)) + T1W'(ll_q);
      t2_q <= a2sq_q * lambda_i;
    end
  end

  // stage 5: distance sum
  logic [SW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q <= SW'(t1_q) + (SW'(t2_q) << 16);
    end
  end

  // stage 6: weight, split in two halves
  logic [SH+ftm_pkg::COEF_W-1:0]    plo_q;
  logic [SW-SH+ftm_pkg::COEF_W-1:0] phi_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      plo_q <= sum_q[SH-1:0] * weight_i;
      phi_q <= sum_q[SW-1:SH] * weight_i;
    end
  end

  // stage 7: cost plus one LSB
  logic [EW-1:0] e_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_q <= (EW'(phi_q) << SH) + EW'(plo_q) + EW'(1);
    end
  end

  // stage 8: leading one
  logic [NW-1:0] lead;
  logic [NW-1:0] n8_q;
  logic [EW-1:0] e8_q;

  always_comb begin
    lead = '0;
    for (int b = 0; b < EW; b++) begin
      if (e_q[b]) lead = NW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n8_q <= lead;
      e8_q <= e_q;
    end
  end

  // stage 9: normalize to Q1.31, then 16 squaring steps
  logic [EW-1:0] e_norm;
  logic [31:0]   y_q  [17];
  logic [FW-1:0] fr_q [17];
  logic [NW-1:0] n_q  [17];

  assign e_norm = e8_q << (NW'(EW - 1) - n8_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      y_q[0]  <= e_norm[EW-1 -: 32];
      fr_q[0] <= '0;
      n_q[0]  <= n8_q;
    end
  end

  for (genvar i = 1; i <= FW; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;

    assign sq = y_q[i-1] * y_q[i-1];
    assign t  = sq[63:31];

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        y_q[i]  <= t[32] ? t[32:1] : t[31:0];
        fr_q[i] <= {fr_q[i-1][FW-2:0], t[32]};
        n_q[i]  <= n_q[i-1];
      end
    end
  end

  assign log_o = {n_q[FW], fr_q[FW]};

endmodule

// File: hw/rtl/ftm_norm_div.sv
module ftm_norm_div #(
  parameter int MEMBERSHIP_BITS = ftm_pkg::MEMBERSHIP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [ftm_pkg::EXP_W-1:0]   u_i,
  input  logic [ftm_pkg::TOT_W-1:0]   tot_i,
  output logic [MEMBERSHIP_BITS:0]    quo_o
);

  localparam int MB   = MEMBERSHIP_BITS;
  localparam int NUMW = ftm_pkg::TOT_W + MB;

  logic [NUMW-1:0]             num;
  logic [NUMW-1:0]             rem_q [MB];
  logic [ftm_pkg::TOT_W-1:0]   tot_q [MB];
  logic [MB:0]                 q_q   [MB+1];

  // rounded numerator: u * 2^MB + S/2
  assign num = (NUMW'(u_i) << MB) + NUMW'(tot_i >> 1);

  // one quotient bit a stage, most significant first
  for (genvar j = 0; j <= MB; j++) begin : g_step
    logic [NUMW-1:0]           rem_in;
    logic [ftm_pkg::TOT_W-1:0] tot_in;
    logic [MB:0]               q_in;
    logic [NUMW-1:0]           den_sh;
    logic                      ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign tot_in = tot_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign tot_in = tot_q[j-1];
      assign q_in   = q_q[j-1];
    end

    assign den_sh = NUMW'(tot_in) << (MB - j);
    assign ge     = rem_in >= den_sh;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        q_q[j] <= {q_in[MB-1:0], ge};
      end
    end

    if (j < MB) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[j] <= ge ? (rem_in - den_sh) : rem_in;
          tot_q[j] <= tot_in;
        end
      end
    end
  end

  assign quo_o = q_q[MB];

endmodule
